// ===== src/bellman_ford_shortest_paths_macros.svh =====
// Assertion macros shared by the shortest path block.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define BFSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bfsp_pkg.sv =====
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;
  localparam int COST_BITS    = 22;
  localparam int SUM_BITS     = COST_BITS + 1;

  localparam int VIDX_BITS = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_BITS = $clog2(MAX_EDGES);
  localparam int ECNT_BITS = $clog2(MAX_EDGES + 1);

  // Configuration register indexes.
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_START_VERTEX = 1'b1;

  typedef enum logic [1:0] {
    KIND_FINITE  = 2'd0,
    KIND_UNREACH = 2'd1,
    KIND_NEGINF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [VIDX_BITS-1:0]          dst;
    logic [VIDX_BITS-1:0]          src;
  } edge_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [COST_BITS-1:0] cost;
    logic                        pred_valid;
    logic [VIDX_BITS-1:0]        pred;
  } vrec_t;

  // Clamps an exact sum into the stored cost range.
  function automatic logic signed [COST_BITS-1:0] sat_cost(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'((1 << (COST_BITS - 1)) - 1);
    lo = -SUM_BITS'(1 << (COST_BITS - 1));
    if (v > hi) begin
      return hi[COST_BITS-1:0];
    end else if (v < lo) begin
      return lo[COST_BITS-1:0];
    end
    return v[COST_BITS-1:0];
  endfunction

endpackage

// ===== src/bellman_ford_shortest_paths.sv =====
// Bellman-Ford single-source shortest paths. Edges arrive one request per
// cycle on the input stream while the block is idle and are kept in a
// 256-entry edge store; edges past that capacity are dropped. The request
// carrying tlast starts a run and the input stays stalled until the last
// result has been taken. With V vertices in use and E stored edges a run
// first initializes the vertex table, then relaxes the edges in 2*(V-1)
// passes (the first V-1 passes find the best costs, the next V-1 passes
// mark every vertex still improvable as minus infinity), then emits one
// result per vertex in ascending order. One shared add/compare unit walks
// the edges; each edge visit reads the edge store, then reads the source
// and destination entries of the vertex table, then compares and writes
// the destination entry back. Results report cost_kind 0 for a finite cost,
// 1 for unreachable and 2 for minus infinity; path_cost is zero unless the
// kind is finite and predecessor is zero unless has_predecessor is set.
// Configuration must be written only while the block is idle (not enforced).
`include "bellman_ford_shortest_paths_macros.svh"

module bellman_ford_shortest_paths
  import bfsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // edge_source[5:0], edge_dest[11:6], edge_weight[27:12]
  input  logic        in_tlast,   // last_edge
  output logic        out_tvalid,
  input  logic        out_tready,
  // vertex_index[5:0], path_cost[27:6], cost_kind[29:28], predecessor[35:30],
  // has_predecessor[36]
  output logic [39:0] out_tdata,
  output logic        out_tlast,  // last_vertex
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_EREAD,
    S_TREAD,
    S_UPD,
    S_OREAD,
    S_OLOAD,
    S_OWAIT
  } state_t;

  state_t state_r;

  logic [VCNT_BITS-1:0] vertex_count_r;
  logic [VIDX_BITS-1:0] start_vertex_r;
  logic [VCNT_BITS-1:0] nv_r;
  logic [ECNT_BITS-1:0] edges_cnt_r;
  logic [ECNT_BITS-1:0] e_r;
  logic [VCNT_BITS-1:0] pass_r;
  logic                 phase_r;   // 0: relaxation passes, 1: negative cycle passes
  logic [VIDX_BITS-1:0] v_r;

  // Edge store and vertex table, both with registered reads.
  edge_t edge_mem [MAX_EDGES];
  vrec_t vt_mem [MAX_VERTICES];
  edge_t edge_rd_r;
  vrec_t vt_rd_s_r;
  vrec_t vt_rd_d_r;

  logic                 out_tvalid_r;
  logic                 out_last_r;
  logic [VIDX_BITS-1:0] out_vertex_r;
  logic [COST_BITS-1:0] out_cost_r;
  kind_t                out_kind_r;
  logic [VIDX_BITS-1:0] out_pred_r;
  logic                 out_pv_r;

  logic                 in_acc;
  logic [VCNT_BITS-1:0] nv_in;
  logic                 edge_ok;
  logic                 last_edge_vis;
  logic                 last_pass;
  logic                 last_vertex;
  logic [VIDX_BITS-1:0] rd_d_addr;

  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] cost_d_ext;
  logic                       vt_we;
  logic [VIDX_BITS-1:0]       vt_wa;
  vrec_t                      vt_wd;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Vertex count in use: zero counts as one, larger values saturate.
  always_comb begin
    nv_in = vertex_count_r;
    if (vertex_count_r == '0) begin
      nv_in = VCNT_BITS'(1);
    end else if (vertex_count_r > VCNT_BITS'(MAX_VERTICES)) begin
      nv_in = VCNT_BITS'(MAX_VERTICES);
    end
  end

  assign last_edge_vis = (e_r + ECNT_BITS'(1)) == edges_cnt_r;
  assign last_pass     = pass_r == (nv_r - VCNT_BITS'(1));
  assign last_vertex   = {1'b0, v_r} == (nv_r - VCNT_BITS'(1));
  assign rd_d_addr     = (state_r == S_OREAD) ? v_r : edge_rd_r.dst;

  // Shared add/compare unit and the single write port of the vertex table.
  always_comb begin
    sum        = SUM_BITS'(vt_rd_s_r.cost) + SUM_BITS'(edge_rd_r.weight);
    cost_d_ext = SUM_BITS'(vt_rd_d_r.cost);
    edge_ok    = ({1'b0, edge_rd_r.src} < nv_r) && ({1'b0, edge_rd_r.dst} < nv_r);
    vt_we      = 1'b0;
    vt_wa      = edge_rd_r.dst;
    vt_wd      = vt_rd_d_r;
    case (state_r)
      S_INIT: begin
        vt_we            = 1'b1;
        vt_wa            = v_r;
        vt_wd.kind       = (v_r == start_vertex_r) ? KIND_FINITE : KIND_UNREACH;
        vt_wd.cost       = '0;
        vt_wd.pred_valid = 1'b0;
        vt_wd.pred       = '0;
      end
      S_UPD: begin
        if (!phase_r) begin
          if (edge_ok && vt_rd_s_r.kind == KIND_FINITE &&
              (vt_rd_d_r.kind == KIND_UNREACH || sum < cost_d_ext)) begin
            vt_we            = 1'b1;
            vt_wd.kind       = KIND_FINITE;
            vt_wd.cost       = sat_cost(sum);
            vt_wd.pred_valid = 1'b1;
            vt_wd.pred       = edge_rd_r.src;
          end
        end else begin
          if (edge_ok && vt_rd_s_r.kind != KIND_UNREACH &&
              vt_rd_d_r.kind != KIND_NEGINF &&
              (vt_rd_s_r.kind == KIND_NEGINF || vt_rd_d_r.kind == KIND_UNREACH ||
               sum < cost_d_ext)) begin
            vt_we            = 1'b1;
            vt_wd.kind       = KIND_NEGINF;
            vt_wd.pred_valid = 1'b0;
            vt_wd.pred       = '0;
          end
        end
      end
      default: begin
        vt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && edges_cnt_r < ECNT_BITS'(MAX_EDGES)) begin
      edge_mem[edges_cnt_r[EIDX_BITS-1:0]] <= edge_t'(in_tdata[27:0]);
    end
    if (state_r == S_EREAD) begin
      edge_rd_r <= edge_mem[e_r[EIDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (vt_we) begin
      vt_mem[vt_wa] <= vt_wd;
    end
    vt_rd_s_r <= vt_mem[edge_rd_r.src];
    vt_rd_d_r <= vt_mem[rd_d_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCNT_BITS'(1);
      start_vertex_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count_r <= cfg_data[VCNT_BITS-1:0];
        REG_START_VERTEX: start_vertex_r <= cfg_data[VIDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edges_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      nv_r         <= VCNT_BITS'(1);
      e_r          <= '0;
      pass_r       <= VCNT_BITS'(1);
      phase_r      <= 1'b0;
      v_r          <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (edges_cnt_r < ECNT_BITS'(MAX_EDGES)) begin
              edges_cnt_r <= edges_cnt_r + ECNT_BITS'(1);
            end
            if (in_tlast) begin
              nv_r    <= nv_in;
              v_r     <= '0;
              state_r <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (last_vertex) begin
            v_r     <= '0;
            e_r     <= '0;
            pass_r  <= VCNT_BITS'(1);
            phase_r <= 1'b0;
            if (nv_r == VCNT_BITS'(1) || edges_cnt_r == '0) begin
              state_r <= S_OREAD;
            end else begin
              state_r <= S_EREAD;
            end
          end else begin
            v_r <= v_r + VIDX_BITS'(1);
          end
        end
        S_EREAD: state_r <= S_TREAD;
        S_TREAD: state_r <= S_UPD;
        S_UPD: begin
          state_r <= S_EREAD;
          if (!last_edge_vis) begin
            e_r <= e_r + ECNT_BITS'(1);
          end else begin
            e_r <= '0;
            if (!last_pass) begin
              pass_r <= pass_r + VCNT_BITS'(1);
            end else if (!phase_r) begin
              pass_r  <= VCNT_BITS'(1);
              phase_r <= 1'b1;
            end else begin
              state_r <= S_OREAD;
            end
          end
        end
        S_OREAD: state_r <= S_OLOAD;
        S_OLOAD: begin
          out_tvalid_r <= 1'b1;
          out_last_r   <= last_vertex;
          out_vertex_r <= v_r;
          out_kind_r   <= vt_rd_d_r.kind;
          out_cost_r   <= (vt_rd_d_r.kind == KIND_FINITE) ? vt_rd_d_r.cost : '0;
          out_pv_r     <= vt_rd_d_r.pred_valid;
          out_pred_r   <= vt_rd_d_r.pred_valid ? vt_rd_d_r.pred : '0;
          state_r      <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (out_last_r) begin
              edges_cnt_r <= '0;
              state_r     <= S_IDLE;
            end else begin
              v_r     <= v_r + VIDX_BITS'(1);
              state_r <= S_OREAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_pv_r, out_pred_r, out_kind_r, out_cost_r, out_vertex_r};

  // A result is only ever offered while input is stalled.
  `BFSP_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready, "result offered while taking edges")
  // The edge count never passes the store capacity.
  `BFSP_ASSERT_NOW(a_cnt_range, 1'b1, edges_cnt_r <= ECNT_BITS'(MAX_EDGES), "edge count overflow")
  // The final result hands the block back to edge loading with an empty store.
  `BFSP_ASSERT_NEXT(a_done_idle, out_tvalid && out_tready && out_tlast,
                    in_tready && edges_cnt_r == '0, "run did not return to idle")
  // A final edge starts a run and stalls input.
  `BFSP_ASSERT_NEXT(a_run_start, in_tvalid && in_tready && in_tlast,
                    !in_tready && !out_tvalid, "final edge did not start a run")

endmodule
